// File: src/idea_pkg.sv
// ----------------------------------------------------------------------------
// idea_pkg: shared types, constants and key schedule functions
// Subkey expansion from the 128-bit key and subkey selection for the
// encrypt and decrypt directions.
// ----------------------------------------------------------------------------
package idea_pkg;

   localparam int ROUND_COUNT  = 8;
   localparam int SUBKEY_COUNT = 52;
   localparam int INV_COUNT    = 18;
   localparam int ROTATE_BITS  = 25;

   localparam logic [1:0] CSR_KEY_FIRST   = 2'd0;
   localparam logic [1:0] CSR_KEY_SECOND  = 2'd1;
   localparam logic [1:0] CSR_DECRYPT     = 2'd2;

   typedef logic [SUBKEY_COUNT-1:0][15:0] subkeys_type;
   typedef logic [INV_COUNT-1:0][15:0]    inv_keys_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_INV  = 3'b010,
      S_RUN  = 3'b100
   } state_type;

   // Each subkey is a fixed 16-bit slice of the key rotated by 25 bits per group of 8.
   function automatic subkeys_type expand_key(logic [63:0] k1, logic [63:0] k2);
      logic [127:0] key;
      subkeys_type  sk;
      int           g;
      int           j;
      int           s;
      int           pos;
      key = {k1[15:0], k1[31:16], k1[47:32], k1[63:48],
             k2[15:0], k2[31:16], k2[47:32], k2[63:48]};
      for (int n = 0; n < SUBKEY_COUNT; n++) begin
         g = n >> 3;
         j = n & 7;
         s = (ROTATE_BITS * g) & 127;
         for (int i = 0; i < 16; i++) begin
            pos = 112 - 16 * j + i;
            sk[n][i] = key[(pos - s + 128) & 127];
         end
      end
      return sk;
   endfunction

   // Forward subkey position whose inverse is kept at slot g.
   function automatic logic [5:0] inv_src(logic [4:0] g);
      logic [5:0] base;
      base = 6'({2'b00, g[4:1]} * 6'd6);
      return base + (g[0] ? 6'd3 : 6'd0);
   endfunction

   function automatic logic [15:0] key_word(subkeys_type fwd, inv_keys_type inv,
                                            logic dec, logic [3:0] rnd, logic [2:0] slot);
      logic [3:0]  rb;
      logic [5:0]  j;
      logic [5:0]  m;
      logic [5:0]  e;
      logic [4:0]  iv;
      logic        outer;
      logic [15:0] r;
      rb    = 4'(ROUND_COUNT) - rnd;
      j     = 6'({2'b00, rb} * 6'd6);
      m     = (rnd == 4'(ROUND_COUNT)) ? 6'd0 : j - 6'd6;
      e     = 6'({2'b00, rnd} * 6'd6) + {3'b000, slot};
      iv    = {rb, 1'b0};
      outer = (rnd == 4'd0) || (rnd == 4'(ROUND_COUNT));
      r     = '0;
      if (!dec) begin
         if (e < 6'(SUBKEY_COUNT)) begin
            r = fwd[e];
         end
      end else begin
         case (slot)
            3'd0: r = inv[iv];
            3'd1: r = 16'd0 - (outer ? fwd[j + 6'd1] : fwd[j + 6'd2]);
            3'd2: r = 16'd0 - (outer ? fwd[j + 6'd2] : fwd[j + 6'd1]);
            3'd3: r = inv[iv + 5'd1];
            3'd4: r = fwd[m + 6'd4];
            3'd5: r = fwd[m + 6'd5];
            default: r = '0;
         endcase
      end
      return r;
   endfunction

endpackage

// File: src/idea_mulmod.sv
// ----------------------------------------------------------------------------
// idea_mulmod: multiply modulo 65537
// Word value 0 stands for 65536; a result of 65536 comes back as 0.
// ----------------------------------------------------------------------------
module idea_mulmod import idea_pkg::*; (
   input  logic [15:0] op_a,
   input  logic [15:0] op_b,
   output logic [15:0] product
);

   logic [16:0] x;
   logic [16:0] y;
   logic [33:0] p;
   logic [15:0] lo;
   logic [16:0] hi;
   logic [17:0] wrap;

   assign x    = {op_a == 16'd0, op_a};
   assign y    = {op_b == 16'd0, op_b};
   assign p    = x * y;
   assign lo   = p[15:0];
   assign hi   = p[32:16];
   assign wrap = {2'b00, lo} + 18'd65537 - {1'b0, hi};

   always_comb begin
      if ({1'b0, lo} >= hi) begin
         product = lo - hi[15:0];
      end else begin
         product = wrap[15:0];
      end
   end

endmodule

// File: src/idea_block_cipher.sv
// ----------------------------------------------------------------------------
// idea_block_cipher: IDEA 64-bit block cipher, 128-bit key, ECB
// One shared mod-65537 multiplier under a small sequencer.
//
//   channel | ports                                  | flow
//   req     | start, busy, req_data_block            | taken when start && !busy
//   rsp     | rsp_strobe, rsp_result_block           | one cycle, no stall
//   csr     | csr_write_enable, csr_index, csr_write_data | write, no wait
//
// An item is loaded, then takes four multiplier passes per round over eight
// rounds and two for the output transform.
// The first decrypt item after a key write first derives the 18 inverse
// subkeys, 30 multiplier passes each.
// Reset clears keys and mode; the result strobe cannot be held off.
// ----------------------------------------------------------------------------
module idea_block_cipher import idea_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_data_block,
   output logic        rsp_strobe,
   output logic [63:0] rsp_result_block,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   state_type    state_ff, state_in;
   logic [1:0]   step_ff, step_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [15:0]  d0_ff, d0_in, d1_ff, d1_in, d2_ff, d2_in, d3_ff, d3_in;
   logic [15:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in, dd_ff, dd_in, t1_ff, t1_in;
   logic [15:0]  acc_ff, acc_in;
   logic [4:0]   g_ff, g_in;
   logic [3:0]   iter_ff, iter_in;
   logic         sq_ff, sq_in;
   inv_keys_type inv_ff, inv_in;
   logic         inv_ready_ff, inv_ready_in;
   logic [63:0]  key_first_ff, key_first_in, key_second_ff, key_second_in;
   logic         mode_ff, mode_in;
   logic         rsp_strobe_ff, rsp_strobe_in;
   logic [63:0]  rsp_block_ff, rsp_block_in;

   subkeys_type  fwd;
   logic [2:0]   mul_slot;
   logic [15:0]  mul_key, add_key1, add_key2;
   logic [15:0]  mul_a, mul_b, mul_out;
   logic [15:0]  t2, t3;

   assign fwd      = expand_key(key_first_ff, key_second_ff);
   assign mul_key  = key_word(fwd, inv_ff, mode_ff, rnd_ff, mul_slot);
   assign add_key1 = key_word(fwd, inv_ff, mode_ff, rnd_ff, 3'd1);
   assign add_key2 = key_word(fwd, inv_ff, mode_ff, rnd_ff, 3'd2);
   assign t2       = mul_out;
   assign t3       = mul_out + t1_ff;

   idea_mulmod u_mul (
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_out)
   );

   always_comb begin
      case (step_ff)
         2'd0:    mul_slot = 3'd0;
         2'd1:    mul_slot = 3'd3;
         2'd2:    mul_slot = 3'd4;
         default: mul_slot = 3'd5;
      endcase
      if (state_ff == S_INV) begin
         mul_a = acc_ff;
         mul_b = sq_ff ? acc_ff : fwd[inv_src(g_ff)];
      end else begin
         mul_b = mul_key;
         case (step_ff)
            2'd0:    mul_a = d0_ff;
            2'd1:    mul_a = d3_ff;
            2'd2:    mul_a = a_ff ^ c_ff;
            default: mul_a = (b_ff ^ dd_ff) + t1_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      rnd_in        = rnd_ff;
      d0_in = d0_ff; d1_in = d1_ff; d2_in = d2_ff; d3_in = d3_ff;
      a_in  = a_ff;  b_in  = b_ff;  c_in  = c_ff;  dd_in = dd_ff; t1_in = t1_ff;
      acc_in        = acc_ff;
      g_in          = g_ff;
      iter_in       = iter_ff;
      sq_in         = sq_ff;
      inv_in        = inv_ff;
      inv_ready_in  = inv_ready_ff;
      key_first_in  = key_first_ff;
      key_second_in = key_second_ff;
      mode_in       = mode_ff;
      rsp_strobe_in = 1'b0;
      rsp_block_in  = rsp_block_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_FIRST: begin
               key_first_in = csr_write_data;
               inv_ready_in = 1'b0;
            end
            CSR_KEY_SECOND: begin
               key_second_in = csr_write_data;
               inv_ready_in  = 1'b0;
            end
            CSR_DECRYPT: mode_in = csr_write_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               d0_in   = req_data_block[15:0];
               d1_in   = req_data_block[31:16];
               d2_in   = req_data_block[47:32];
               d3_in   = req_data_block[63:48];
               step_in = 2'd0;
               rnd_in  = 4'd0;
               if (mode_ff && !inv_ready_ff) begin
                  state_in = S_INV;
                  g_in     = 5'd0;
                  iter_in  = 4'd0;
                  sq_in    = 1'b1;
                  acc_in   = fwd[inv_src(5'd0)];
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_INV: begin
            acc_in = mul_out;
            sq_in  = !sq_ff;
            if (!sq_ff) begin
               if (iter_ff == 4'd14) begin
                  inv_in[g_ff] = mul_out;
                  iter_in      = 4'd0;
                  if (g_ff == 5'(INV_COUNT - 1)) begin
                     inv_ready_in = 1'b1;
                     state_in     = S_RUN;
                  end else begin
                     g_in   = g_ff + 5'd1;
                     acc_in = fwd[inv_src(g_ff + 5'd1)];
                  end
               end else begin
                  iter_in = iter_ff + 4'd1;
               end
            end
         end
         S_RUN: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0: begin
                  a_in = mul_out;
                  if (rnd_ff == 4'(ROUND_COUNT)) begin
                     b_in = d2_ff + add_key1;
                     c_in = d1_ff + add_key2;
                  end else begin
                     b_in = d1_ff + add_key1;
                     c_in = d2_ff + add_key2;
                  end
               end
               2'd1: begin
                  dd_in = mul_out;
                  if (rnd_ff == 4'(ROUND_COUNT)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_block_in  = {mul_out, c_ff, b_ff, a_ff};
                     state_in      = S_IDLE;
                  end
               end
               2'd2: t1_in = mul_out;
               default: begin
                  d0_in  = a_ff ^ t2;
                  d1_in  = c_ff ^ t2;
                  d2_in  = b_ff ^ t3;
                  d3_in  = dd_ff ^ t3;
                  rnd_in = rnd_ff + 4'd1;
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         rnd_ff        <= '0;
         g_ff          <= '0;
         iter_ff       <= '0;
         sq_ff         <= 1'b0;
         inv_ready_ff  <= 1'b0;
         key_first_ff  <= '0;
         key_second_ff <= '0;
         mode_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rnd_ff        <= rnd_in;
         g_ff          <= g_in;
         iter_ff       <= iter_in;
         sq_ff         <= sq_in;
         inv_ready_ff  <= inv_ready_in;
         key_first_ff  <= key_first_in;
         key_second_ff <= key_second_in;
         mode_ff       <= mode_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      d0_ff        <= d0_in;
      d1_ff        <= d1_in;
      d2_ff        <= d2_in;
      d3_ff        <= d3_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      dd_ff        <= dd_in;
      t1_ff        <= t1_in;
      acc_ff       <= acc_in;
      inv_ff       <= inv_in;
      rsp_block_ff <= rsp_block_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_block = rsp_block_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   a_inv_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INV) |-> (!inv_ready_ff && mode_ff))
      else $error("inverse derivation with ready set or encrypt mode");

endmodule
